// File: rtl/core/plr_pkg.sv
package plr_pkg;

   localparam int PIN_BYTES   = 15;
   localparam int LOW_BYTES   = 8;
   localparam int HIGH_BYTES  = PIN_BYTES - LOW_BYTES;
   localparam int MIN_PIN_LEN = 4;

   localparam logic [3:0]  FAIL_MAX     = 4'hF;
   localparam logic [31:0] IDLE_MAX     = 32'hFFFF_FFFF;
   localparam logic [63:0] TICKS_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] PIN_LOW_RST  = 64'h0000_0000_3030_3030;
   localparam logic [55:0] PIN_HIGH_RST = 56'h0;

   localparam logic [31:0] IDLE_TIMEOUT_RST  = 32'd300;
   localparam logic [3:0]  MAX_ATTEMPTS_RST  = 4'd5;
   localparam logic [31:0] LOCKOUT_TICKS_RST = 32'd30000;

   localparam logic [7:0] CSR_IDLE_TIMEOUT  = 8'd0;
   localparam logic [7:0] CSR_MAX_ATTEMPTS  = 8'd1;
   localparam logic [7:0] CSR_LOCKOUT_TICKS = 8'd2;

   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_ACTIVITY   = 3'd1,
      CMD_LOCK       = 3'd2,
      CMD_UNLOCK     = 3'd3,
      CMD_CHANGE_PIN = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_WRONG_PIN  = 2'd1,
      ST_LOCKED_OUT = 2'd2,
      ST_BAD_PIN    = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] now_ticks;
      logic [63:0] lock_end;
      logic [63:0] pin_low;
      logic [55:0] pin_high;
      logic [63:0] new_pin_low;
      logic [55:0] new_pin_high;
      logic        new_pin_ok;
   } item_type;

   typedef struct packed {
      logic [31:0] idle_timeout;
      logic [3:0]  max_attempts;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic       is_locked;
      logic [3:0] failures;
   } result_type;

endpackage

// File: rtl/core/pin_lock_with_retry_lockout.sv
// PIN lock controller with retry lockout. Takes one command item per clock
// while req_stall is low and returns one result item per command. The
// accepting edge registers the command, its PINs cut at the first zero byte
// (the new PIN also at its length) and the lockout end time summed; once the
// result register is free or read, an edge applies the command to the lock
// state in one pass and loads the result register. While a result waits, the
// input register still takes one more item; req_stall rises only when both
// registers are full and the result is stalled. The user writes configuration
// via the csr_ port (index 0 idle timeout, 1 max attempts, 2 lockout ticks) only
// while the block is idle, which it does not enforce; csr_ready is always high.
module pin_lock_with_retry_lockout (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_now_ticks,
   input  logic [63:0] req_pin_low,
   input  logic [55:0] req_pin_high,
   input  logic [63:0] req_new_pin_low,
   input  logic [55:0] req_new_pin_high,
   input  logic [3:0]  req_new_pin_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_locked,
   output logic [3:0]  rsp_failures,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic                in_valid_ff, in_valid_in;
   plr_pkg::item_type   item_ff, item_in;
   logic                out_valid_ff, out_valid_in;
   plr_pkg::result_type out_ff;
   plr_pkg::result_type result;
   plr_pkg::cfg_type    cfg_ff;
   logic [31:0]         lockout_ticks_ff;
   logic                advance;
   logic                accept;
   logic [64:0]         end_sum;
   logic [63:0]         pin_low_m, new_low_m;
   logic [55:0]         pin_high_m, new_high_m;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout <= plr_pkg::IDLE_TIMEOUT_RST;
         cfg_ff.max_attempts <= plr_pkg::MAX_ATTEMPTS_RST;
         lockout_ticks_ff    <= plr_pkg::LOCKOUT_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            plr_pkg::CSR_IDLE_TIMEOUT:  cfg_ff.idle_timeout <= csr_wdata;
            plr_pkg::CSR_MAX_ATTEMPTS:  cfg_ff.max_attempts <= csr_wdata[3:0];
            plr_pkg::CSR_LOCKOUT_TICKS: lockout_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   plr_pin_mask u_old_pin (
      .pin_low     (req_pin_low),
      .pin_high    (req_pin_high),
      .limit       (4'(plr_pkg::PIN_BYTES)),
      .masked_low  (pin_low_m),
      .masked_high (pin_high_m)
   );

   plr_pin_mask u_new_pin (
      .pin_low     (req_new_pin_low),
      .pin_high    (req_new_pin_high),
      .limit       (req_new_pin_length),
      .masked_low  (new_low_m),
      .masked_high (new_high_m)
   );

   assign end_sum = {1'b0, req_now_ticks} + {33'd0, lockout_ticks_ff};

   always_comb begin
      item_in.cmd          = plr_pkg::cmd_type'(req_command);
      item_in.now_ticks    = req_now_ticks;
      item_in.lock_end     = end_sum[64] ? plr_pkg::TICKS_MAX : end_sum[63:0];
      item_in.pin_low      = pin_low_m;
      item_in.pin_high     = pin_high_m;
      item_in.new_pin_low  = new_low_m;
      item_in.new_pin_high = new_high_m;
      item_in.new_pin_ok   = new_low_m[(plr_pkg::MIN_PIN_LEN - 1) * 8 +: 8] != 8'h00;
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
      if (advance) out_ff <= result;
   end

   plr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_is_locked = out_ff.is_locked;
   assign rsp_failures  = out_ff.failures;

endmodule

// File: rtl/core/plr_pin_mask.sv
module plr_pin_mask (
   input  logic [63:0] pin_low,
   input  logic [55:0] pin_high,
   input  logic [3:0]  limit,
   output logic [63:0] masked_low,
   output logic [55:0] masked_high
);

   logic [119:0] full;
   logic [119:0] kept;

   assign full = {pin_high, pin_low};

   always_comb begin
      logic run;
      run  = 1'b1;
      kept = '0;
      for (int i = 0; i < plr_pkg::PIN_BYTES; i++) begin
         run     = run && (full[i*8 +: 8] != 8'h00) && (4'(i) < limit);
         kept[i*8 +: 8] = run ? full[i*8 +: 8] : 8'h00;
      end
   end

   assign masked_low  = kept[63:0];
   assign masked_high = kept[119:64];

endmodule

// File: rtl/core/plr_core.sv
module plr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  plr_pkg::item_type   item,
   input  plr_pkg::cfg_type    cfg,
   output plr_pkg::result_type result
);

   logic        locked_ff, locked_in;
   logic [31:0] idle_ff, idle_in;
   logic [3:0]  fail_ff, fail_in;
   logic [63:0] lock_end_ff, lock_end_in;
   logic [63:0] stored_low_ff, stored_low_in;
   logic [55:0] stored_high_ff, stored_high_in;
   plr_pkg::status_type status;
   logic        match;

   assign match = (item.pin_low == stored_low_ff) && (item.pin_high == stored_high_ff);

   always_comb begin
      logic [31:0] idle_next;
      logic        over;
      logic        blocked;
      logic [3:0]  fail_base;
      logic [3:0]  fail_next;
      locked_in      = locked_ff;
      idle_in        = idle_ff;
      fail_in        = fail_ff;
      lock_end_in    = lock_end_ff;
      stored_low_in  = stored_low_ff;
      stored_high_in = stored_high_ff;
      status         = plr_pkg::ST_OK;
      idle_next      = (idle_ff == plr_pkg::IDLE_MAX) ? idle_ff : idle_ff + 32'd1;
      over           = fail_ff >= cfg.max_attempts;
      blocked        = over && (item.now_ticks < lock_end_ff);
      fail_base      = (over && !blocked) ? 4'd0 : fail_ff;
      fail_next      = (fail_base == plr_pkg::FAIL_MAX) ? fail_base : fail_base + 4'd1;
      unique case (item.cmd)
         plr_pkg::CMD_TICK: begin
            if (!locked_ff && (cfg.idle_timeout != 32'd0)) begin
               idle_in = idle_next;
               if (idle_next >= cfg.idle_timeout) locked_in = 1'b1;
            end
         end
         plr_pkg::CMD_ACTIVITY: idle_in = '0;
         plr_pkg::CMD_LOCK:     locked_in = 1'b1;
         plr_pkg::CMD_UNLOCK: begin
            if (locked_ff) begin
               priority if (blocked) begin
                  status = plr_pkg::ST_LOCKED_OUT;
               end else if (match) begin
                  locked_in = 1'b0;
                  fail_in   = '0;
                  idle_in   = '0;
               end else begin
                  fail_in = fail_next;
                  if (fail_next >= cfg.max_attempts) lock_end_in = item.lock_end;
                  status = plr_pkg::ST_WRONG_PIN;
               end
            end
         end
         plr_pkg::CMD_CHANGE_PIN: begin
            priority if (!item.new_pin_ok) begin
               status = plr_pkg::ST_BAD_PIN;
            end else if (!match) begin
               status = plr_pkg::ST_WRONG_PIN;
            end else begin
               stored_low_in  = item.new_pin_low;
               stored_high_in = item.new_pin_high;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff      <= 1'b0;
         idle_ff        <= '0;
         fail_ff        <= '0;
         lock_end_ff    <= '0;
         stored_low_ff  <= plr_pkg::PIN_LOW_RST;
         stored_high_ff <= plr_pkg::PIN_HIGH_RST;
      end else if (advance) begin
         locked_ff      <= locked_in;
         idle_ff        <= idle_in;
         fail_ff        <= fail_in;
         lock_end_ff    <= lock_end_in;
         stored_low_ff  <= stored_low_in;
         stored_high_ff <= stored_high_in;
      end
   end

   assign result.status    = status;
   assign result.is_locked = locked_in;
   assign result.failures  = fail_in;

endmodule

// File: tb/pin_lock_monitor.sv
module pin_lock_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_now_ticks,
   input  logic [63:0] req_pin_low,
   input  logic [55:0] req_pin_high,
   input  logic [63:0] req_new_pin_low,
   input  logic [55:0] req_new_pin_high,
   input  logic [3:0]  req_new_pin_length,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_is_locked,
   input  logic [3:0]  rsp_failures,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          pending,
   output int          commands_seen,
   output int          results_checked,
   output int          refusals,
   output int          wrong_pins
);
   timeunit 1ns;
   timeprecision 1ps;
   import plr_pkg::*;

   logic [31:0]  idle_limit;
   logic [3:0]   attempt_limit;
   logic [31:0]  lockout_len;

   logic         locked;
   logic [31:0]  idle_cnt;
   logic [3:0]   fail_cnt;
   logic [63:0]  lockout_until;
   logic [119:0] stored_pin;

   result_type   awaited_answers[$];

   function automatic logic [119:0] keep_bytes(input logic [119:0] v, input int n);
      logic [119:0] mask;
      mask = (120'd1 << (8 * n)) - 120'd1;
      return v & mask;
   endfunction

   function automatic int text_length(input logic [119:0] v, input int limit);
      for (int i = 0; i < limit; i++) begin
         if (v[8 * i +: 8] == 8'd0)
            return i;
      end
      return limit;
   endfunction

   function automatic logic pin_equal(input logic [119:0] pin);
      return keep_bytes(pin, text_length(pin, PIN_BYTES)) == stored_pin;
   endfunction

   function automatic result_type apply_command(input logic [2:0] cmd, input logic [63:0] now,
                                                input logic [119:0] pin,
                                                input logic [119:0] new_pin,
                                                input logic [3:0] new_len);
      result_type  r;
      logic        blocked;
      int          len;
      logic [64:0] sum;
      r.status = ST_OK;
      case (cmd)
         CMD_TICK: begin
            if (!locked && idle_limit != 32'd0) begin
               if (idle_cnt != IDLE_MAX)
                  idle_cnt = idle_cnt + 32'd1;
               if (idle_cnt >= idle_limit)
                  locked = 1'b1;
            end
         end
         CMD_ACTIVITY: idle_cnt = 32'd0;
         CMD_LOCK: locked = 1'b1;
         CMD_UNLOCK: begin
            if (locked) begin
               blocked = 1'b0;
               if (fail_cnt >= attempt_limit) begin
                  if (now < lockout_until)
                     blocked = 1'b1;
                  else
                     fail_cnt = 4'd0;
               end
               if (blocked) begin
                  r.status = ST_LOCKED_OUT;
               end else if (pin_equal(pin)) begin
                  locked   = 1'b0;
                  fail_cnt = 4'd0;
                  idle_cnt = 32'd0;
               end else begin
                  if (fail_cnt != FAIL_MAX)
                     fail_cnt = fail_cnt + 4'd1;
                  if (fail_cnt >= attempt_limit) begin
                     sum = {1'b0, now} + {33'd0, lockout_len};
                     lockout_until = sum[64] ? TICKS_MAX : sum[63:0];
                  end
                  r.status = ST_WRONG_PIN;
               end
            end
         end
         CMD_CHANGE_PIN: begin
            len = text_length(new_pin, int'(new_len));
            if (len < MIN_PIN_LEN)
               r.status = ST_BAD_PIN;
            else if (!pin_equal(pin))
               r.status = ST_WRONG_PIN;
            else
               stored_pin = keep_bytes(new_pin, len);
         end
         default: ;
      endcase
      r.is_locked = locked;
      r.failures  = fail_cnt;
      return r;
   endfunction

   always @(posedge clock) begin : track
      result_type want;
      if (reset) begin
         idle_limit    = IDLE_TIMEOUT_RST;
         attempt_limit = MAX_ATTEMPTS_RST;
         lockout_len   = LOCKOUT_TICKS_RST;
         locked        = 1'b0;
         idle_cnt      = 32'd0;
         fail_cnt      = 4'd0;
         lockout_until = 64'd0;
         stored_pin    = {PIN_HIGH_RST, PIN_LOW_RST};
         awaited_answers.delete();
         mismatches      = 0;
         pending         = 0;
         commands_seen   = 0;
         results_checked = 0;
         refusals        = 0;
         wrong_pins      = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDLE_TIMEOUT:  idle_limit = csr_wdata;
               CSR_MAX_ATTEMPTS:  attempt_limit = csr_wdata[3:0];
               CSR_LOCKOUT_TICKS: lockout_len = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d locked %0d failures %0d",
                           rsp_status, rsp_is_locked, rsp_failures);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_status !== want.status || rsp_is_locked !== want.is_locked ||
                   rsp_failures !== want.failures) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch on result %0d: expected status %0d locked %0d ",
                               "failures %0d, got status %0d locked %0d failures %0d"},
                              results_checked, want.status, want.is_locked, want.failures,
                              rsp_status, rsp_is_locked, rsp_failures);
               end
            end
         end
         if (req_valid && !req_stall) begin
            commands_seen++;
            want = apply_command(req_command, req_now_ticks, {req_pin_high, req_pin_low},
                                 {req_new_pin_high, req_new_pin_low}, req_new_pin_length);
            if (want.status == ST_LOCKED_OUT)
               refusals++;
            if (want.status == ST_WRONG_PIN)
               wrong_pins++;
            awaited_answers.push_back(want);
         end
         pending = awaited_answers.size();
      end
   end

endmodule

// File: tb/pin_lock_with_retry_lockout_test.sv
module pin_lock_with_retry_lockout_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plr_pkg::*;

   localparam int STALL_LIMIT      = 4000;
   localparam int RANDOM_PER_PHASE = 80;
   localparam int PHASES           = 6;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [63:0] req_now_ticks;
   logic [63:0] req_pin_low;
   logic [55:0] req_pin_high;
   logic [63:0] req_new_pin_low;
   logic [55:0] req_new_pin_high;
   logic [3:0]  req_new_pin_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_is_locked;
   logic [3:0]  rsp_failures;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;

   int mismatches;
   int pending;
   int commands_seen;
   int results_checked;
   int refusals;
   int wrong_pins;

   logic [119:0] pin_pool[4];
   int           pin_size[4];
   logic [63:0]  now_clock;
   int           burst_left;
   int           settings_used;
   int           idle_cycles = 0;

   logic [31:0] idle_set[PHASES]     = '{32'd3, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd300};
   logic [3:0]  attempts_set[PHASES] = '{4'd2, 4'd1, 4'd15, 4'd0, 4'd3, 4'd5};
   logic [31:0] ticks_set[PHASES]    = '{32'd200, 32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd1500,
                                         32'd30000};

   pin_lock_with_retry_lockout uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_now_ticks(req_now_ticks),
      .req_pin_low(req_pin_low),
      .req_pin_high(req_pin_high),
      .req_new_pin_low(req_new_pin_low),
      .req_new_pin_high(req_new_pin_high),
      .req_new_pin_length(req_new_pin_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_is_locked(rsp_is_locked),
      .rsp_failures(rsp_failures),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pin_lock_monitor lock_watch (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_now_ticks(req_now_ticks),
      .req_pin_low(req_pin_low),
      .req_pin_high(req_pin_high),
      .req_new_pin_low(req_new_pin_low),
      .req_new_pin_high(req_new_pin_high),
      .req_new_pin_length(req_new_pin_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_is_locked(rsp_is_locked),
      .rsp_failures(rsp_failures),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .pending(pending),
      .commands_seen(commands_seen),
      .results_checked(results_checked),
      .refusals(refusals),
      .wrong_pins(wrong_pins)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [119:0] random_bits();
      logic [127:0] w;
      w = {$urandom, $urandom, $urandom, $urandom};
      return w[119:0];
   endfunction

   function automatic logic [119:0] low_bytes_mask(input int n);
      return (120'd1 << (8 * n)) - 120'd1;
   endfunction

   function automatic logic [119:0] text_pin(input string s);
      logic [119:0] v;
      v = '0;
      for (int i = 0; i < s.len(); i++)
         v[8 * i +: 8] = s[i];
      return v;
   endfunction

   function automatic logic [119:0] candidate_pin();
      int           k;
      int           roll;
      logic [119:0] p;
      k    = $urandom_range(3);
      p    = pin_pool[k];
      roll = $urandom_range(9);
      if (roll < 2 && pin_size[k] < 14)
         p = p | (random_bits() & ~low_bytes_mask(pin_size[k] + 1));
      else if (roll == 2)
         p[8 * $urandom_range(pin_size[k] - 1) +: 8] = 8'($urandom_range(255, 1));
      return p;
   endfunction

   task automatic send(input logic [2:0] cmd, input logic [63:0] now,
                       input logic [119:0] pin, input logic [119:0] new_pin,
                       input logic [3:0] new_len);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(12, 1)) @(negedge clock);
         burst_left = $urandom_range(40, 1);
      end
      req_command        = cmd;
      req_now_ticks      = now;
      req_pin_low        = pin[63:0];
      req_pin_high       = pin[119:64];
      req_new_pin_low    = new_pin[63:0];
      req_new_pin_high   = new_pin[119:64];
      req_new_pin_length = new_len;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_settings(input logic [31:0] idle, input logic [3:0] attempts,
                                 input logic [31:0] ticks);
      logic [7:0]  index_of[3];
      logic [31:0] reg_value[3];
      index_of  = '{CSR_IDLE_TIMEOUT, CSR_MAX_ATTEMPTS, CSR_LOCKOUT_TICKS};
      reg_value = '{idle, {28'd0, attempts}, ticks};
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_valid = 1'b1;
         csr_index = index_of[i];
         csr_wdata = reg_value[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid = 1'b0;
      settings_used++;
   endtask

   task automatic random_command();
      logic [2:0]   cmd;
      logic [63:0]  now;
      logic [119:0] pin;
      logic [119:0] new_pin;
      logic [3:0]   new_len;
      int           roll;
      int           shape;
      int           k;
      roll = $urandom_range(99);
      if (roll < 10) begin
         cmd     = 3'($urandom_range(7));
         now     = {$urandom, $urandom};
         pin     = random_bits();
         new_pin = random_bits();
         new_len = 4'($urandom_range(15));
      end else begin
         if (roll < 35)
            cmd = CMD_TICK;
         else if (roll < 45)
            cmd = CMD_ACTIVITY;
         else if (roll < 53)
            cmd = CMD_LOCK;
         else if (roll < 85)
            cmd = CMD_UNLOCK;
         else
            cmd = CMD_CHANGE_PIN;
         now_clock = now_clock + 64'($urandom_range(2500));
         if ($urandom_range(49) == 0)
            now_clock = now_clock + {24'd0, $urandom, 8'd0};
         now     = now_clock;
         pin     = candidate_pin();
         k       = $urandom_range(3);
         new_pin = pin_pool[k];
         new_len = 4'(pin_size[k]);
         shape   = $urandom_range(9);
         // keep the stored pin inside the pool: only too-short lengths, terminated
         // garbage beyond the pin, or unterminated garbage cut off by the length
         if (shape == 0) begin
            new_len = 4'($urandom_range(3));
         end else if (shape == 1 && pin_size[k] < 15) begin
            new_len = 4'($urandom_range(15, pin_size[k] + 1));
            new_pin = new_pin | (random_bits() & ~low_bytes_mask(pin_size[k] + 1));
         end else if (shape == 2) begin
            new_pin = new_pin | (random_bits() & ~low_bytes_mask(pin_size[k]));
         end
      end
      send(cmd, now, pin, new_pin, new_len);
   endtask

   initial begin : receiver
      int mode;
      int left;
      rsp_stall = 1'b0;
      mode      = 0;
      left      = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(3);
            left = $urandom_range(128, 16);
         end
         left--;
         case (mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(3) == 0);
            2: rsp_stall = ($urandom_range(4) != 0);
            default: rsp_stall = ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [119:0] zero_pin;
      logic [119:0] all_ones;
      logic [119:0] p0000;
      logic [119:0] p1234;
      logic [119:0] p98765;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = '0;
      req_now_ticks      = '0;
      req_pin_low        = '0;
      req_pin_high       = '0;
      req_new_pin_low    = '0;
      req_new_pin_high   = '0;
      req_new_pin_length = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      now_clock          = 64'd1000;
      burst_left         = 0;
      settings_used      = 1;

      zero_pin = '0;
      all_ones = '1;
      p0000    = text_pin("0000");
      p1234    = text_pin("1234");
      p98765   = text_pin("98765");
      pin_pool[0] = p0000;
      pin_size[0] = 4;
      pin_pool[1] = all_ones;
      pin_size[1] = 15;
      for (int k = 2; k < 4; k++) begin
         pin_size[k] = $urandom_range(15, 4);
         pin_pool[k] = '0;
         for (int i = 0; i < pin_size[k]; i++)
            pin_pool[k][8 * i +: 8] = 8'($urandom_range(255, 1));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(CMD_TICK, 64'd0, zero_pin, zero_pin, 4'd0);
      send(CMD_ACTIVITY, 64'd0, zero_pin, zero_pin, 4'd0);
      send(CMD_UNLOCK, 64'd50, p1234, zero_pin, 4'd0);
      send(CMD_LOCK, 64'd0, zero_pin, zero_pin, 4'd0);
      send(CMD_UNLOCK, 64'd100, p1234, zero_pin, 4'd0);
      send(CMD_UNLOCK, 64'd120, p0000 | (random_bits() & ~low_bytes_mask(5)), zero_pin, 4'd0);
      send(CMD_CHANGE_PIN, 64'd0, p0000, p1234, 4'd3);
      send(CMD_CHANGE_PIN, 64'd0, p0000, text_pin("12"), 4'd4);
      send(CMD_CHANGE_PIN, 64'd0, p0000, p1234, 4'd0);
      send(CMD_CHANGE_PIN, 64'd0, p1234, p1234, 4'd4);
      send(CMD_CHANGE_PIN, 64'd0, p0000, all_ones, 4'd15);
      send(CMD_CHANGE_PIN, 64'd0, all_ones,
           text_pin("9876543") | (random_bits() & ~low_bytes_mask(8)), 4'd5);
      send(CMD_LOCK, 64'd0, zero_pin, zero_pin, 4'd0);
      repeat (5) send(CMD_UNLOCK, 64'd500, all_ones, zero_pin, 4'd0);
      send(CMD_UNLOCK, 64'd30499, p98765, zero_pin, 4'd0);
      send(CMD_UNLOCK, 64'd30500, p98765, zero_pin, 4'd0);
      for (int c = 5; c < 8; c++)
         send(3'(c), TICKS_MAX, all_ones, all_ones, 4'd15);
      send(CMD_CHANGE_PIN, 64'd0, p98765, p0000 | (all_ones & ~low_bytes_mask(5)), 4'd4);

      write_settings(32'd0, 4'd1, 32'hFFFF_FFFF);
      send(CMD_LOCK, 64'd0, zero_pin, zero_pin, 4'd0);
      send(CMD_UNLOCK, TICKS_MAX - 64'd5, p1234, zero_pin, 4'd0);
      send(CMD_UNLOCK, TICKS_MAX - 64'd1, p0000, zero_pin, 4'd0);
      send(CMD_UNLOCK, TICKS_MAX, p0000, zero_pin, 4'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         write_settings(idle_set[ph], attempts_set[ph], ticks_set[ph]);
         repeat (RANDOM_PER_PHASE) begin
            if ($urandom_range(99) == 0)
               drain();
            random_command();
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("run covered %0d commands and %0d checked results over %0d register settings",
               commands_seen, results_checked, settings_used);
      $display("attempts refused in lockout: %0d, wrong PIN answers: %0d",
               refusals, wrong_pins);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
